/* rtl/core/tree_hierarchical_lock_macros.svh */
// ----------------------------------------------------------------------------
// tree_hierarchical_lock_macros.svh
// Assertion helpers for the hierarchical lock manager.
// ----------------------------------------------------------------------------
`ifndef TREE_HIERARCHICAL_LOCK_MACROS_SVH
`define TREE_HIERARCHICAL_LOCK_MACROS_SVH
`ifndef SYNTH
// Plain property, sampled on clk_i, off during reset
`define THL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tree_hierarchical_lock assertion failed");
// Implication in the same cycle
`define THL_ASSERT_IMPL(lbl, ante, cons) \
  `THL_ASSERT(lbl, (ante) |-> (cons))
`else
`define THL_ASSERT(lbl, prop)
`define THL_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

/* rtl/core/thl_pkg.sv */
// ----------------------------------------------------------------------------
// thl_pkg
// Types, codes and defaults shared by the hierarchical lock manager.
// ----------------------------------------------------------------------------
package thl_pkg;

  // Default parameter values
  localparam int NodesDef    = 256;
  localparam int MaxDepthDef = 32;

  // Nodes addressable by an 8-bit index
  localparam int NodeSpace = 256;

  typedef enum logic [1:0] {
    CMD_LINK   = 2'd0,
    CMD_LOCK   = 2'd1,
    CMD_UNLOCK = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH,
    S_WALK,
    S_COMMIT,
    S_ADJ,
    S_RESP
  } ctrl_state_e;

  // Node memory read address source
  typedef enum logic [1:0] {
    RD_IN,      // node index of the incoming request
    RD_RDPAR,   // parent of the entry just read
    RD_ENTPAR   // parent of the captured request node
  } rd_sel_e;

  // Node memory write source
  typedef enum logic [2:0] {
    WR_NONE,
    WR_CLEAR,
    WR_LINK,
    WR_COMMIT,
    WR_ADJ
  } wr_sel_e;

  // One node memory entry
  typedef struct packed {
    logic        root;
    logic [7:0]  parent;
    logic        locked;
    logic [15:0] count;
  } node_ent_t;

  // Controller to datapath
  typedef struct packed {
    logic    accept;
    logic    clr_inc;
    logic    rd_en;
    rd_sel_e rd_sel;
    wr_sel_e wr_sel;
    logic    capture_ent;
    logic    walk_step;
    logic    depth_clr;
    logic    res_load;
    logic    res_answer;
    logic    res_locked;
    logic    res_status;
    logic    out_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    cmd_e cmd;
    logic node_oor;
    logic link_ok;
    logic rd_locked;
    logic rd_root;
    logic rd_count_zero;
    logic seen_now;
    logic depth_hit;
    logic ent_root;
    logic clr_last;
    logic out_busy;
  } dp_stat_t;

endpackage

/* rtl/core/thl_datapath.sv */
// ----------------------------------------------------------------------------
// thl_datapath
// Node memory, request and walk registers, result and output registers.
// ----------------------------------------------------------------------------
module thl_datapath #(
  parameter int NODES     = thl_pkg::NodesDef,
  parameter int MAX_DEPTH = thl_pkg::MaxDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  thl_pkg::dp_cmd_t  cmd_i,
  output thl_pkg::dp_stat_t stat_o,
  input  logic [1:0]        cmd_in_i,
  input  logic [7:0]        node_index_i,
  input  logic [7:0]        parent_index_i,
  input  logic              is_root_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              answer_o,
  output logic              node_locked_o,
  output logic              status_o
);

  // Only the first 256 nodes are reachable through an 8-bit index
  localparam int Depth  = (NODES < thl_pkg::NodeSpace) ? NODES : thl_pkg::NodeSpace;
  localparam int IdxW   = $clog2(Depth);
  localparam int DepthW = $clog2(MAX_DEPTH + 1);

  thl_pkg::node_ent_t mem [Depth];

  thl_pkg::cmd_e      req_cmd_q;
  logic [7:0]         req_node_q;
  logic [7:0]         req_parent_q;
  logic               req_root_q;
  thl_pkg::node_ent_t rd_q, ent_q;
  logic [IdxW-1:0]    rd_addr_q, rd_addr;
  logic [IdxW-1:0]    clr_q;
  logic [DepthW-1:0]  depth_q, depth_d;
  logic               seen_q;
  logic               res_answer_q, res_locked_q, res_status_q;
  logic               out_valid_q;
  logic               answer_q, locked_q, status_q;
  logic               wr_en;
  logic [IdxW-1:0]    wr_addr;
  thl_pkg::node_ent_t wr_data;
  logic [IdxW-1:0]    node_addr;

  assign node_addr = req_node_q[IdxW-1:0];

  // Read address select
  always_comb begin
    unique case (cmd_i.rd_sel)
      thl_pkg::RD_IN:    rd_addr = node_index_i[IdxW-1:0];
      thl_pkg::RD_RDPAR: rd_addr = rd_q.parent[IdxW-1:0];
      default:           rd_addr = ent_q.parent[IdxW-1:0];
    endcase
  end

  // Write port select
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = node_addr;
    wr_data = rd_q;
    unique case (cmd_i.wr_sel)
      thl_pkg::WR_CLEAR: begin
        wr_addr = clr_q;
        wr_data = '{root: 1'b1, parent: 8'd0, locked: 1'b0, count: 16'd0};
      end
      thl_pkg::WR_LINK: begin
        wr_data.root   = req_root_q;
        wr_data.parent = req_root_q ? 8'd0 : req_parent_q;
      end
      thl_pkg::WR_COMMIT: begin
        wr_data        = ent_q;
        wr_data.locked = (req_cmd_q == thl_pkg::CMD_LOCK);
      end
      thl_pkg::WR_ADJ: begin
        wr_addr = rd_addr_q;
        // Saturating count update
        if (req_cmd_q == thl_pkg::CMD_LOCK) begin
          if (rd_q.count != 16'hFFFF) wr_data.count = rd_q.count + 16'd1;
        end else begin
          if (rd_q.count != 16'd0) wr_data.count = rd_q.count - 16'd1;
        end
      end
      default: wr_en = 1'b0;
    endcase
  end

  // Node memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q      <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  // Request capture and captured node entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_cmd_q    <= thl_pkg::cmd_e'(cmd_in_i);
      req_node_q   <= node_index_i;
      req_parent_q <= parent_index_i;
      req_root_q   <= is_root_i;
    end
    if (cmd_i.capture_ent) begin
      ent_q <= rd_q;
    end
    if (cmd_i.res_load) begin
      res_answer_q <= cmd_i.res_answer;
      res_locked_q <= cmd_i.res_locked;
      res_status_q <= cmd_i.res_status;
    end
    if (cmd_i.out_load) begin
      answer_q <= res_answer_q;
      locked_q <= res_locked_q;
      status_q <= res_status_q;
    end
  end

  // Walk depth counter
  always_comb begin
    depth_d = (cmd_i.depth_clr ? '0 : depth_q) + DepthW'(cmd_i.walk_step);
    if (cmd_i.accept) depth_d = '0;
  end

  // Control registers: clear sweep, walk state, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      depth_q     <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_inc) clr_q <= clr_q + IdxW'(1);
      depth_q <= depth_d;
      if (cmd_i.accept) begin
        seen_q <= 1'b0;
      end else if (cmd_i.walk_step) begin
        seen_q <= seen_q | rd_q.locked;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Status to controller
  always_comb begin
    stat_o.cmd           = req_cmd_q;
    stat_o.node_oor      = ({24'd0, req_node_q} >= 32'(NODES));
    stat_o.link_ok       = req_root_q || ({24'd0, req_parent_q} < 32'(NODES));
    stat_o.rd_locked     = rd_q.locked;
    stat_o.rd_root       = rd_q.root;
    stat_o.rd_count_zero = (rd_q.count == 16'd0);
    stat_o.seen_now      = seen_q | rd_q.locked;
    stat_o.depth_hit     = (depth_q >= DepthW'(MAX_DEPTH));
    stat_o.ent_root      = ent_q.root;
    stat_o.clr_last      = (clr_q == IdxW'(Depth - 1));
    stat_o.out_busy      = out_valid_q && !out_ready_i;
  end

  assign out_valid_o   = out_valid_q;
  assign answer_o      = answer_q;
  assign node_locked_o = locked_q;
  assign status_o      = status_q;

endmodule

/* rtl/core/thl_ctrl.sv */
// ----------------------------------------------------------------------------
// thl_ctrl
// Sequencer for link, lock, unlock and query over the node memory.
// ----------------------------------------------------------------------------
module thl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  thl_pkg::dp_stat_t stat_i,
  output thl_pkg::dp_cmd_t  cmd_o
);

  thl_pkg::ctrl_state_e state_q, state_d;
  logic is_lock, is_unlock;

  assign is_lock   = (stat_i.cmd == thl_pkg::CMD_LOCK);
  assign is_unlock = (stat_i.cmd == thl_pkg::CMD_UNLOCK);

  // Next state after one ancestor check
  function automatic thl_pkg::ctrl_state_e walk_next(thl_pkg::dp_stat_t st, logic lk);
    thl_pkg::ctrl_state_e ns;
    if (st.rd_root) begin
      ns = (lk && st.seen_now) ? thl_pkg::S_RESP : thl_pkg::S_COMMIT;
    end else if (st.depth_hit) begin
      ns = thl_pkg::S_RESP;
    end else begin
      ns = thl_pkg::S_WALK;
    end
    return ns;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= thl_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      thl_pkg::S_CLEAR: if (stat_i.clr_last) state_d = thl_pkg::S_IDLE;
      thl_pkg::S_IDLE:  if (in_valid_i) state_d = thl_pkg::S_FETCH;
      thl_pkg::S_FETCH: begin
        if (stat_i.node_oor) begin
          state_d = thl_pkg::S_RESP;
        end else begin
          unique case (stat_i.cmd)
            thl_pkg::CMD_LOCK: begin
              if (stat_i.rd_locked || !stat_i.rd_count_zero) state_d = thl_pkg::S_RESP;
              else state_d = walk_next(stat_i, 1'b1);
            end
            thl_pkg::CMD_UNLOCK: begin
              if (!stat_i.rd_locked) state_d = thl_pkg::S_RESP;
              else state_d = walk_next(stat_i, 1'b0);
            end
            default: state_d = thl_pkg::S_RESP;
          endcase
        end
      end
      thl_pkg::S_WALK:   state_d = walk_next(stat_i, is_lock);
      thl_pkg::S_COMMIT: state_d = stat_i.ent_root ? thl_pkg::S_RESP : thl_pkg::S_ADJ;
      thl_pkg::S_ADJ: begin
        if (stat_i.rd_root || stat_i.depth_hit) state_d = thl_pkg::S_RESP;
      end
      thl_pkg::S_RESP: if (!stat_i.out_busy) state_d = thl_pkg::S_IDLE;
      default: state_d = thl_pkg::S_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    logic walk;
    walk       = 1'b0;
    cmd_o      = '0;
    cmd_o.rd_sel = thl_pkg::RD_IN;
    cmd_o.wr_sel = thl_pkg::WR_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      thl_pkg::S_CLEAR: begin
        cmd_o.wr_sel  = thl_pkg::WR_CLEAR;
        cmd_o.clr_inc = 1'b1;
      end
      thl_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          cmd_o.rd_en  = 1'b1;
        end
      end
      thl_pkg::S_FETCH: begin
        cmd_o.capture_ent = 1'b1;
        if (stat_i.node_oor) begin
          cmd_o.res_load = 1'b1;
        end else begin
          unique case (stat_i.cmd)
            thl_pkg::CMD_LINK: begin
              if (stat_i.link_ok) cmd_o.wr_sel = thl_pkg::WR_LINK;
              cmd_o.res_load   = 1'b1;
              cmd_o.res_answer = stat_i.link_ok;
              cmd_o.res_locked = stat_i.rd_locked;
            end
            thl_pkg::CMD_LOCK: begin
              if (stat_i.rd_locked) begin
                cmd_o.res_load   = 1'b1;
                cmd_o.res_answer = 1'b1;
                cmd_o.res_locked = 1'b1;
              end else if (!stat_i.rd_count_zero) begin
                cmd_o.res_load = 1'b1;
              end else begin
                walk = 1'b1;
              end
            end
            thl_pkg::CMD_UNLOCK: begin
              if (!stat_i.rd_locked) begin
                cmd_o.res_load   = 1'b1;
                cmd_o.res_answer = 1'b1;
              end else begin
                walk = 1'b1;
              end
            end
            default: begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_answer = stat_i.rd_locked;
              cmd_o.res_locked = stat_i.rd_locked;
            end
          endcase
        end
      end
      thl_pkg::S_WALK: walk = 1'b1;
      thl_pkg::S_COMMIT: begin
        cmd_o.wr_sel = thl_pkg::WR_COMMIT;
        if (stat_i.ent_root) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_answer = 1'b1;
          cmd_o.res_locked = is_lock;
        end else begin
          cmd_o.depth_clr = 1'b1;
          cmd_o.walk_step = 1'b1;
          cmd_o.rd_en     = 1'b1;
          cmd_o.rd_sel    = thl_pkg::RD_ENTPAR;
        end
      end
      thl_pkg::S_ADJ: begin
        cmd_o.wr_sel = thl_pkg::WR_ADJ;
        if (!stat_i.rd_root && !stat_i.depth_hit) begin
          cmd_o.walk_step = 1'b1;
          cmd_o.rd_en     = 1'b1;
          cmd_o.rd_sel    = thl_pkg::RD_RDPAR;
        end else begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_answer = 1'b1;
          cmd_o.res_locked = is_lock;
        end
      end
      thl_pkg::S_RESP: cmd_o.out_load = !stat_i.out_busy;
      default: ;
    endcase

    // Ancestor check step, shared by fetch and walk
    if (walk) begin
      if (stat_i.rd_root) begin
        if (is_lock && stat_i.seen_now) cmd_o.res_load = 1'b1;
      end else if (stat_i.depth_hit) begin
        cmd_o.res_load   = 1'b1;
        cmd_o.res_locked = is_unlock;
        cmd_o.res_status = 1'b1;
      end else begin
        cmd_o.walk_step = 1'b1;
        cmd_o.rd_en     = 1'b1;
        cmd_o.rd_sel    = thl_pkg::RD_RDPAR;
      end
    end
  end

endmodule

/* rtl/core/tree_hierarchical_lock.sv */
// ----------------------------------------------------------------------------
// tree_hierarchical_lock
// Hierarchical lock manager with per-node locked descendant counts.
// ----------------------------------------------------------------------------
// One request at a time runs against a node memory with separate read and
// write ports, holding parent link, root flag, locked bit and a saturating
// 16-bit descendant count per node. After reset the block sweeps all
// min(NODES, 256) entries with in_ready_o low. Link, query, out-of-range and
// early-exit lock/unlock requests are answered from the fetch state without
// a walk. A lock or unlock that walks its ancestors first checks each of
// them, then commits the node and then updates each ancestor's count. A lock
// is refused when the walk finds a locked ancestor. A walk longer than
// MAX_DEPTH returns status 1 and leaves the state untouched. A finished
// result sits in an output register while the next request is accepted.
`include "tree_hierarchical_lock_macros.svh"

module tree_hierarchical_lock #(
  parameter int NODES     = thl_pkg::NodesDef,
  parameter int MAX_DEPTH = thl_pkg::MaxDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] cmd_i,
  input  logic [7:0] node_index_i,
  input  logic [7:0] parent_index_i,
  input  logic       is_root_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       answer_o,
  output logic       node_locked_o,
  output logic       status_o
);

  thl_pkg::dp_cmd_t  dp_cmd;
  thl_pkg::dp_stat_t dp_stat;

  thl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  thl_datapath #(
    .NODES     (NODES),
    .MAX_DEPTH (MAX_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .stat_o         (dp_stat),
    .cmd_in_i       (cmd_i),
    .node_index_i   (node_index_i),
    .parent_index_i (parent_index_i),
    .is_root_i      (is_root_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .answer_o       (answer_o),
    .node_locked_o  (node_locked_o),
    .status_o       (status_o)
  );

  // No memory write while a new request can be taken
  `THL_ASSERT_IMPL(a_idle_no_write, in_ready_o, dp_cmd.wr_sel == thl_pkg::WR_NONE)
  // A pending result is never overwritten
  `THL_ASSERT_IMPL(a_no_overwrite, dp_cmd.out_load, !(out_valid_o && !out_ready_i))
  // Depth error never reports success
  `THL_ASSERT_IMPL(a_err_no_answer, dp_cmd.res_load && dp_cmd.res_status, !dp_cmd.res_answer)
  // Result is delivered the cycle after it leaves the controller
  `THL_ASSERT(a_out_after_load, dp_cmd.out_load |=> out_valid_o)

endmodule
